[sv/bpfa_pkg.sv]
// bpfa_pkg: shared types and constants of the bitmap page frame allocator
// no dependencies; imported by the channel interfaces, bpfa_find and the top module

package bpfa_pkg;

   localparam int ADDR_W    = 48;
   localparam int COUNT_W   = 13;
   localparam int WORD_BITS = 64;
   localparam int BIT_W     = 6;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic CSR_BASE_ADDRESS = 1'b0;
   localparam logic CSR_PAGE_COUNT   = 1'b1;

   localparam logic [COUNT_W-1:0] PAGE_COUNT_RESET = 13'd4096;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_OOM    = 2'd1,
      ST_DOUBLE = 2'd2,
      ST_RANGE  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_ALLOC_START,
      S_ALLOC_SCAN,
      S_ALLOC_ADDR,
      S_FREE_CALC,
      S_FREE_CHECK,
      S_FREE_READ,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] pos;
   } find_result_type;

   // bits below position n set, n from 0 to WORD_BITS
   function automatic logic [WORD_BITS-1:0] below_mask(input logic [BIT_W:0] n);
      logic [WORD_BITS-1:0] m;
      for (int j = 0; j < WORD_BITS; j++) begin
         m[j] = ((BIT_W + 1)'(j) < n);
      end
      return m;
   endfunction

endpackage

[sv/bpfa_channels.sv]
// bpfa channels: request, response and register write interfaces
// depends on bpfa_pkg

interface bpfa_req_if import bpfa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              mode;
   logic [ADDR_W-1:0] free_address;
   modport source(output valid, mode, free_address, input ready);
   modport sink(input valid, mode, free_address, output ready);
endinterface

interface bpfa_rsp_if import bpfa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] page_address;
   status_type        status;
   modport source(output valid, page_address, status, input ready);
   modport sink(input valid, page_address, status, output ready);
endinterface

interface bpfa_csr_if import bpfa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              index;
   logic [ADDR_W-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

[sv/bpfa_ram.sv]
// bpfa_ram: generic single write port, single read port ram with registered read
// no dependencies

module bpfa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[sv/bpfa_find.sv]
// bpfa_find: first clear bit of a bitmap word within a window mask
// depends on bpfa_pkg

module bpfa_find import bpfa_pkg::*; (
   input  logic [WORD_BITS-1:0] word,
   input  logic [WORD_BITS-1:0] mask,
   output find_result_type      result
);

   localparam int LANES = WORD_BITS / 8;

   logic [WORD_BITS-1:0] cand;
   logic [LANES-1:0]     lane_any;
   logic [BIT_W-4:0]     lane_sel;
   logic [7:0]           lane_bits;
   logic [2:0]           bit_sel;

   always_comb begin
      cand = ~word & mask;
      for (int k = 0; k < LANES; k++) begin
         lane_any[k] = |cand[k*8 +: 8];
      end
      // lowest lane with a candidate
      lane_sel = '0;
      for (int k = LANES - 1; k >= 0; k--) begin
         if (lane_any[k]) begin
            lane_sel = (BIT_W - 3)'(k);
         end
      end
      lane_bits = cand[{lane_sel, 3'b000} +: 8];
      bit_sel = '0;
      for (int b = 7; b >= 0; b--) begin
         if (lane_bits[b]) begin
            bit_sel = 3'(b);
         end
      end
      result.found = |lane_any;
      result.pos   = {lane_sel, bit_sel};
   end

endmodule

[sv/bitmap_page_frame_allocator_top.sv]
// bitmap_page_frame_allocator_top: next-fit page frame allocator over a used bitmap
// depends on bpfa_pkg, bpfa_channels, bpfa_ram, bpfa_find
//
// req_port takes one word: mode 0 allocates a page, mode 1 frees the page
// holding free_address. rsp_port returns one word per request: page_address
// (zero on free and on any error) and status (ok, out of memory, double free,
// out of range). csr_port writes base_address (index 0) and page_count
// (index 1); it is always ready. It must be written only while the block is idle:
// the user is bound to this and the block itself does not enforce it. The bitmap
// sits in a ram of 64-bit words; one word is read and checked per cycle by a
// find-first-clear unit under a small sequencer. An allocate scans from 1 up to
// MAX_PAGES/64 (rounded up) + 1 words, starting at the word of the scan pointer;
// out of memory with no managed pages scans none, and a free reads its bitmap
// word only when in range. One request is in work at a time; req_ready is high
// only while idle, which starts in the cycle the response word appears.
// After reset a clearing pass writes zero to every bitmap word, one word a
// cycle, with req_ready low.
// The response sits in an output register; a stalled receiver holds it there
// and the next request is still taken, finishing work waits for the register.

module bitmap_page_frame_allocator_top import bpfa_pkg::*; #(
   parameter int MAX_PAGES  = 4096,
   parameter int PAGE_BYTES = 4096
) (
   input  logic          clock,
   input  logic          reset,
   bpfa_req_if.sink      req_port,
   bpfa_rsp_if.source    rsp_port,
   bpfa_csr_if.sink      csr_port
);

   localparam int WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int XW    = WA_W + BIT_W;
   localparam int CW    = XW + 1;
   localparam int PB_SH = $clog2(PAGE_BYTES);
   localparam logic [WA_W-1:0] LAST_WORD    = WA_W'(WORDS - 1);
   localparam logic [31:0]     MAX_PAGES_32 = 32'(MAX_PAGES);

   state_type state_ff, state_in;

   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [COUNT_W-1:0] pcount_ff, pcount_in;
   logic [XW-1:0]      sp_ff, sp_in;
   logic               mode_ff, mode_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [ADDR_W-1:0]  off_ff, off_in;
   logic               below_ff, below_in;
   logic [XW-1:0]      fidx_ff, fidx_in;
   logic [XW-1:0]      p0_ff, p0_in;
   logic [WA_W-1:0]    lw_ff, lw_in;
   logic [BIT_W:0]     lim_ff, lim_in;
   logic [WA_W-1:0]    w_ff, w_in;
   logic               wrap_ff, wrap_in;
   logic [WA_W-1:0]    clr_ff, clr_in;
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in;
   status_type         res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   status_type         rsp_status_ff, rsp_status_in;

   logic [31:0]          pc32;
   logic [CW-1:0]        count;
   logic [CW-1:0]        cm1;
   logic [XW-1:0]        p0_calc;
   logic [WA_W-1:0]      sw;
   logic                 at_start;
   logic                 scan_end;
   logic [WA_W-1:0]      next_w;
   logic [WORD_BITS-1:0] ge_mask;
   logic [WORD_BITS-1:0] lt_mask;
   logic [ADDR_W-1:0]    idx48;
   logic                 f_range;
   logic                 fbit;
   logic                 load_out;
   find_result_type      find;

   logic                 ram_we;
   logic [WA_W-1:0]      ram_waddr;
   logic [WORD_BITS-1:0] ram_wdata;
   logic [WA_W-1:0]      ram_raddr;
   logic [WORD_BITS-1:0] ram_rdata;

   bpfa_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(WORDS)
   ) u_map (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   bpfa_find u_find (
      .word(ram_rdata),
      .mask(ge_mask & lt_mask),
      .result(find)
   );

   // shared scan and free arithmetic
   always_comb begin
      pc32     = 32'(pcount_ff);
      count    = (pc32 > MAX_PAGES_32) ? CW'(MAX_PAGES_32) : CW'(pc32);
      cm1      = count - CW'(1);
      p0_calc  = (CW'(sp_ff) < count) ? sp_ff : '0;
      sw       = p0_ff[XW-1:BIT_W];
      at_start = (w_ff == sw);
      scan_end = wrap_ff && at_start;
      next_w   = (w_ff == lw_ff) ? '0 : w_ff + WA_W'(1);
      ge_mask  = (at_start && !wrap_ff) ? ~below_mask({1'b0, p0_ff[BIT_W-1:0]}) : '1;
      if (at_start && wrap_ff) begin
         lt_mask = below_mask({1'b0, p0_ff[BIT_W-1:0]});
      end else if (w_ff == lw_ff) begin
         lt_mask = below_mask(lim_ff);
      end else begin
         lt_mask = '1;
      end
      idx48   = off_ff >> PB_SH;
      f_range = below_ff || (idx48 >= ADDR_W'(count));
      fbit    = ram_rdata[fidx_ff[BIT_W-1:0]];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == LAST_WORD) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_port.valid) begin
               state_in = (req_port.mode == MODE_ALLOC) ? S_ALLOC_START : S_FREE_CALC;
            end
         end
         S_ALLOC_START: begin
            state_in = (count == '0) ? S_RESULT : S_ALLOC_SCAN;
         end
         S_ALLOC_SCAN: begin
            if (find.found) begin
               state_in = S_ALLOC_ADDR;
            end else if (scan_end) begin
               state_in = S_RESULT;
            end
         end
         S_ALLOC_ADDR: state_in = S_RESULT;
         S_FREE_CALC:  state_in = S_FREE_CHECK;
         S_FREE_CHECK: state_in = f_range ? S_RESULT : S_FREE_READ;
         S_FREE_READ:  state_in = S_RESULT;
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_port.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // handshake and ram control
   always_comb begin
      req_port.ready = (state_ff == S_IDLE);
      csr_port.ready = 1'b1;
      load_out       = 1'b0;
      ram_we         = 1'b0;
      ram_waddr      = w_ff;
      ram_wdata      = ram_rdata;
      ram_raddr      = '0;
      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
         end
         S_ALLOC_START: ram_raddr = p0_calc[XW-1:BIT_W];
         S_ALLOC_SCAN: begin
            ram_raddr = next_w;
            if (find.found) begin
               ram_we    = 1'b1;
               ram_waddr = w_ff;
               ram_wdata = ram_rdata | (WORD_BITS'(1) << find.pos);
            end
         end
         S_FREE_CHECK: ram_raddr = idx48[XW-1:BIT_W];
         S_FREE_READ: begin
            if (fbit) begin
               ram_we    = 1'b1;
               ram_waddr = fidx_ff[XW-1:BIT_W];
               ram_wdata = ram_rdata & ~(WORD_BITS'(1) << fidx_ff[BIT_W-1:0]);
            end
         end
         S_RESULT: load_out = !rsp_valid_ff || rsp_port.ready;
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      base_in       = base_ff;
      pcount_in     = pcount_ff;
      sp_in         = sp_ff;
      mode_in       = mode_ff;
      addr_in       = addr_ff;
      off_in        = off_ff;
      below_in      = below_ff;
      fidx_in       = fidx_ff;
      p0_in         = p0_ff;
      lw_in         = lw_ff;
      lim_in        = lim_ff;
      w_in          = w_ff;
      wrap_in       = wrap_ff;
      clr_in        = clr_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         S_CLEAR: clr_in = clr_ff + WA_W'(1);
         S_IDLE: begin
            if (req_port.valid) begin
               mode_in = req_port.mode;
               addr_in = req_port.free_address;
            end
         end
         S_ALLOC_START: begin
            p0_in         = p0_calc;
            lw_in         = cm1[XW-1:BIT_W];
            lim_in        = {1'b0, cm1[BIT_W-1:0]} + (BIT_W + 1)'(1);
            w_in          = p0_calc[XW-1:BIT_W];
            wrap_in       = 1'b0;
            res_addr_in   = '0;
            res_status_in = ST_OOM;
         end
         S_ALLOC_SCAN: begin
            if (find.found) begin
               sp_in         = {w_ff, find.pos};
               res_status_in = ST_OK;
            end else if (!scan_end) begin
               w_in = next_w;
               if (w_ff == lw_ff) wrap_in = 1'b1;
            end
         end
         S_ALLOC_ADDR: res_addr_in = base_ff + (ADDR_W'(sp_ff) << PB_SH);
         S_FREE_CALC: begin
            below_in    = addr_ff < base_ff;
            off_in      = addr_ff - base_ff;
            res_addr_in = '0;
         end
         S_FREE_CHECK: begin
            fidx_in       = idx48[XW-1:0];
            res_status_in = f_range ? ST_RANGE : ST_OK;
         end
         S_FREE_READ: res_status_in = fbit ? ST_OK : ST_DOUBLE;
         default: ;
      endcase

      if (csr_port.valid) begin
         case (csr_port.index)
            CSR_BASE_ADDRESS: base_in   = csr_port.data;
            CSR_PAGE_COUNT:   pcount_in = csr_port.data[COUNT_W-1:0];
            default: ;
         endcase
      end

      if (load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_addr_in   = res_addr_ff;
         rsp_status_in = res_status_ff;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         base_ff      <= '0;
         pcount_ff    <= PAGE_COUNT_RESET;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         base_ff      <= base_in;
         pcount_ff    <= pcount_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      addr_ff       <= addr_in;
      off_ff        <= off_in;
      below_ff      <= below_in;
      fidx_ff       <= fidx_in;
      p0_ff         <= p0_in;
      lw_ff         <= lw_in;
      lim_ff        <= lim_in;
      w_ff          <= w_in;
      wrap_ff       <= wrap_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.page_address = rsp_addr_ff;
   assign rsp_port.status       = rsp_status_ff;

   // successful allocate returns the page under the scan pointer
   a_alloc_addr: assert property (@(posedge clock) disable iff (reset)
      (load_out && mode_ff == MODE_ALLOC && res_status_ff == ST_OK) |->
         (res_addr_ff == base_ff + (ADDR_W'(sp_ff) << PB_SH)))
      else $error("allocated address does not match scan pointer");

   // errors and frees carry a zero address
   a_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (load_out && (mode_ff == MODE_FREE || res_status_ff != ST_OK)) |->
         (res_addr_ff == '0))
      else $error("nonzero address on free or error");

   // the second lap never passes the start word
   a_lap_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ALLOC_SCAN && wrap_ff) |-> (w_ff <= sw))
      else $error("scan ran past its start word");

   // scan pointer stays inside the bitmap
   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      (32'(sp_ff) < MAX_PAGES_32))
      else $error("scan pointer out of range");

   // a finished scan writes back the word it found a clear bit in
   a_scan_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ALLOC_SCAN && find.found) |=>
         (state_ff == S_ALLOC_ADDR && $past(ram_we)))
      else $error("found page not marked used");

endmodule
